// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pslsel_pkg.sv -----
`default_nettype none
package pslsel_pkg;

	// field widths
	localparam int POS_W      = 16;
	localparam int HEAD_W     = 16;
	localparam int SPEED_W    = 12;
	localparam int DIST_W     = 33;
	localparam int CNT_W      = 7;
	localparam int GOAL_W     = 3;
	localparam int SOCIAL_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 33;

	// derived datapath widths
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = (SQ_W + 1 > DIST_W + 1) ? SQ_W + 1 : DIST_W + 1;
	localparam int PROD_W = DIFF_W + HEAD_W;
	localparam int DOT_W  = PROD_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DIST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_DIST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CAP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CROWD_CAP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CAP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CROWD_LIMIT = 3'd7;

	// register reset values
	localparam logic [DIST_W-1:0]  RST_SLOW_DIST   = 33'd16384;
	localparam logic [DIST_W-1:0]  RST_CLOSE_DIST  = 33'd23716;
	localparam logic [DIST_W-1:0]  RST_MID_DIST    = 33'd147456;
	localparam logic [DIST_W-1:0]  RST_FAR_DIST    = 33'd589824;
	localparam logic [SPEED_W-1:0] RST_CLOSE_CAP   = 12'd77;
	localparam logic [SPEED_W-1:0] RST_CROWD_CAP   = 12'd102;
	localparam logic [SPEED_W-1:0] RST_SINGLE_CAP  = 12'd128;
	localparam logic [CNT_W-1:0]   RST_CROWD_LIMIT = 7'd2;

	// saturation points
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

	// weight codes in halves
	localparam logic [GOAL_W-1:0]   GOAL_CLOSE   = 3'd3;
	localparam logic [GOAL_W-1:0]   GOAL_MID     = 3'd4;
	localparam logic [GOAL_W-1:0]   GOAL_FAR     = 3'd5;
	localparam logic [GOAL_W-1:0]   GOAL_OPEN    = 3'd6;
	localparam logic [GOAL_W-1:0]   GOAL_EMPTY   = 3'd5;
	localparam logic [SOCIAL_W-1:0] SOCIAL_CLOSE = 4'd8;
	localparam logic [SOCIAL_W-1:0] SOCIAL_MID   = 4'd4;
	localparam logic [SOCIAL_W-1:0] SOCIAL_FAR   = 4'd2;
	localparam logic [SOCIAL_W-1:0] SOCIAL_OPEN  = 4'd1;
	localparam logic [SOCIAL_W-1:0] SOCIAL_EMPTY = 4'd1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic multiply;
		logic accumulate;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic item_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/pslsel_ctrl.sv -----
`default_nettype none
module pslsel_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  pslsel_pkg::dp_sts_t  sts,
	output pslsel_pkg::dp_cmd_t  cmd
);
	import pslsel_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// output register can take a new result when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.multiply = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = sts.item_last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pslsel_dp.sv -----
`default_nettype none
module pslsel_dp (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  pslsel_pkg::dp_cmd_t                   cmd,
	output pslsel_pkg::dp_sts_t                   sts,
	input  wire                                   cfg_we,
	input  wire  [pslsel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [pslsel_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   robot_pos_x,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   robot_pos_y,
	input  wire  signed [pslsel_pkg::HEAD_W-1:0]  heading_cos,
	input  wire  signed [pslsel_pkg::HEAD_W-1:0]  heading_sin,
	input  wire  [pslsel_pkg::SPEED_W-1:0]        default_speed,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   person_pos_x,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   person_pos_y,
	input  wire                                   person_valid,
	input  wire                                   last_person,
	output logic [pslsel_pkg::SPEED_W-1:0]        speed_limit,
	output logic [pslsel_pkg::GOAL_W-1:0]         goal_weight_halves,
	output logic [pslsel_pkg::SOCIAL_W-1:0]       social_weight_halves,
	output logic [pslsel_pkg::DIST_W-1:0]         nearest_dist_sq,
	output logic                                  someone_ahead,
	output logic [pslsel_pkg::CNT_W-1:0]          ahead_count
);
	import pslsel_pkg::*;

	// configuration registers
	logic [DIST_W-1:0]  slow_dist_q;
	logic [DIST_W-1:0]  close_dist_q;
	logic [DIST_W-1:0]  mid_dist_q;
	logic [DIST_W-1:0]  far_dist_q;
	logic [SPEED_W-1:0] close_cap_q;
	logic [SPEED_W-1:0] crowd_cap_q;
	logic [SPEED_W-1:0] single_cap_q;
	logic [CNT_W-1:0]   crowd_limit_q;

	// captured item
	logic signed [POS_W-1:0]  rx_q, ry_q, px_q, py_q;
	logic signed [HEAD_W-1:0] hc_q, hs_q;
	logic [SPEED_W-1:0]       speed_q;
	logic                     valid_q;
	logic                     last_q;

	// products
	logic [SQ_W-1:0]          sqx_q, sqy_q;
	logic signed [PROD_W-1:0] dotx_q, doty_q;

	// frame accumulators
	logic              frame_open_q;
	logic              nonempty_q;
	logic [DIST_W-1:0] min_q;
	logic [CNT_W-1:0]  cnt_q;

	// output payload
	logic [SPEED_W-1:0]  speed_out_q;
	logic [GOAL_W-1:0]   goal_out_q;
	logic [SOCIAL_W-1:0] social_out_q;
	logic [DIST_W-1:0]   near_out_q;
	logic                ahead_out_q;
	logic [CNT_W-1:0]    count_out_q;

	// combinational nets
	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [SQ_W-1:0]   sqx, sqy;
	logic [SUM_W-1:0]         d2_sum;
	logic [DIST_W-1:0]        d2_sat;
	logic signed [DOT_W-1:0]  dot;
	logic                     in_front;
	logic [DIST_W-1:0]        base_min;
	logic [CNT_W-1:0]         base_cnt;
	logic                     base_ne;
	logic                     front_seen;
	logic [SPEED_W-1:0]       cap;
	logic                     use_cap;
	logic [SPEED_W-1:0]       speed_sel;
	logic [GOAL_W-1:0]        goal_sel;
	logic [SOCIAL_W-1:0]      social_sel;

	assign sts.item_last = last_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_dist_q   <= RST_SLOW_DIST;
			close_dist_q  <= RST_CLOSE_DIST;
			mid_dist_q    <= RST_MID_DIST;
			far_dist_q    <= RST_FAR_DIST;
			close_cap_q   <= RST_CLOSE_CAP;
			crowd_cap_q   <= RST_CROWD_CAP;
			single_cap_q  <= RST_SINGLE_CAP;
			crowd_limit_q <= RST_CROWD_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOW_DIST:   slow_dist_q   <= cfg_wdata[DIST_W-1:0];
				CFG_CLOSE_DIST:  close_dist_q  <= cfg_wdata[DIST_W-1:0];
				CFG_MID_DIST:    mid_dist_q    <= cfg_wdata[DIST_W-1:0];
				CFG_FAR_DIST:    far_dist_q    <= cfg_wdata[DIST_W-1:0];
				CFG_CLOSE_CAP:   close_cap_q   <= cfg_wdata[SPEED_W-1:0];
				CFG_CROWD_CAP:   crowd_cap_q   <= cfg_wdata[SPEED_W-1:0];
				CFG_SINGLE_CAP:  single_cap_q  <= cfg_wdata[SPEED_W-1:0];
				CFG_CROWD_LIMIT: crowd_limit_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rx_q    <= robot_pos_x;
			ry_q    <= robot_pos_y;
			hc_q    <= heading_cos;
			hs_q    <= heading_sin;
			speed_q <= default_speed;
			px_q    <= person_pos_x;
			py_q    <= person_pos_y;
			valid_q <= person_valid;
			last_q  <= last_person;
		end
	end

	// offsets and products
	assign dx  = DIFF_W'(px_q) - DIFF_W'(rx_q);
	assign dy  = DIFF_W'(py_q) - DIFF_W'(ry_q);
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_ff @(posedge clk) begin
		if (cmd.multiply) begin
			sqx_q  <= sqx;
			sqy_q  <= sqy;
			dotx_q <= dx * hc_q;
			doty_q <= dy * hs_q;
		end
	end

	// squared distance with saturation, heading test
	assign d2_sum   = SUM_W'(sqx_q) + SUM_W'(sqy_q);
	assign d2_sat   = (|d2_sum[SUM_W-1:DIST_W]) ? DIST_MAX : d2_sum[DIST_W-1:0];
	assign dot      = DOT_W'(dotx_q) + DOT_W'(doty_q);
	assign in_front = !dot[DOT_W-1] && (dot != '0) && (d2_sat < far_dist_q);

	// first item of a frame starts from cleared accumulators
	assign base_min = frame_open_q ? min_q : DIST_MAX;
	assign base_cnt = frame_open_q ? cnt_q : '0;
	assign base_ne  = frame_open_q && nonempty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			nonempty_q   <= 1'b0;
			min_q        <= DIST_MAX;
			cnt_q        <= '0;
		end else if (cmd.accumulate) begin
			frame_open_q <= !last_q;
			if (valid_q) begin
				nonempty_q <= 1'b1;
				min_q      <= (d2_sat < base_min) ? d2_sat : base_min;
				cnt_q      <= (in_front && base_cnt != CNT_MAX) ? base_cnt + 1'b1 : base_cnt;
			end else begin
				nonempty_q <= base_ne;
				min_q      <= base_min;
				cnt_q      <= base_cnt;
			end
		end
	end

	// speed ladder
	assign front_seen = (cnt_q != '0);

	always_comb begin
		cap     = single_cap_q;
		use_cap = 1'b0;
		priority if (min_q < slow_dist_q) begin
			cap     = close_cap_q;
			use_cap = 1'b1;
		end else if (front_seen && cnt_q > crowd_limit_q) begin
			cap     = crowd_cap_q;
			use_cap = 1'b1;
		end else if (front_seen) begin
			cap     = single_cap_q;
			use_cap = 1'b1;
		end
		speed_sel = (use_cap && cap < speed_q) ? cap : speed_q;
	end

	// weight ladder
	always_comb begin
		priority if (!nonempty_q) begin
			goal_sel   = GOAL_EMPTY;
			social_sel = SOCIAL_EMPTY;
		end else if (min_q < close_dist_q) begin
			goal_sel   = GOAL_CLOSE;
			social_sel = SOCIAL_CLOSE;
		end else if (min_q < mid_dist_q) begin
			goal_sel   = GOAL_MID;
			social_sel = SOCIAL_MID;
		end else if (min_q < far_dist_q) begin
			goal_sel   = GOAL_FAR;
			social_sel = SOCIAL_FAR;
		end else begin
			goal_sel   = GOAL_OPEN;
			social_sel = SOCIAL_OPEN;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			speed_out_q  <= nonempty_q ? speed_sel : speed_q;
			goal_out_q   <= goal_sel;
			social_out_q <= social_sel;
			near_out_q   <= min_q;
			ahead_out_q  <= front_seen;
			count_out_q  <= cnt_q;
		end
	end

	assign speed_limit          = speed_out_q;
	assign goal_weight_halves   = goal_out_q;
	assign social_weight_halves = social_out_q;
	assign nearest_dist_sq      = near_out_q;
	assign someone_ahead        = ahead_out_q;
	assign ahead_count          = count_out_q;

endmodule
`default_nettype wire

// ----- rtl/core/proximity_speed_limit_selector.sv -----
// sequence: each accepted item steps through capture, multiply and accumulate before the next accept
// a last item then also loads the result register, waiting while that register is full and stalled
// input: no new item is accepted until the controller has stepped the last one through
// the shared multiply and accumulate stages; a stalled result holds off only the last item
// reset: arst_n clears control, frame accumulators and loads register defaults at once
`default_nettype none
`include "assert_macros.svh"
module proximity_speed_limit_selector (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   robot_pos_x,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   robot_pos_y,
	input  wire  signed [pslsel_pkg::HEAD_W-1:0]  heading_cos,
	input  wire  signed [pslsel_pkg::HEAD_W-1:0]  heading_sin,
	input  wire  [pslsel_pkg::SPEED_W-1:0]        default_speed,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   person_pos_x,
	input  wire  signed [pslsel_pkg::POS_W-1:0]   person_pos_y,
	input  wire                                   person_valid,
	input  wire                                   last_person,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [pslsel_pkg::SPEED_W-1:0]        speed_limit,
	output logic [pslsel_pkg::GOAL_W-1:0]         goal_weight_halves,
	output logic [pslsel_pkg::SOCIAL_W-1:0]       social_weight_halves,
	output logic [pslsel_pkg::DIST_W-1:0]         nearest_dist_sq,
	output logic                                  someone_ahead,
	output logic [pslsel_pkg::CNT_W-1:0]          ahead_count,
	input  wire                                   cfg_we,
	input  wire  [pslsel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [pslsel_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pslsel_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing
	pslsel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic, accumulators and result register
	pslsel_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.robot_pos_x          (robot_pos_x),
		.robot_pos_y          (robot_pos_y),
		.heading_cos          (heading_cos),
		.heading_sin          (heading_sin),
		.default_speed        (default_speed),
		.person_pos_x         (person_pos_x),
		.person_pos_y         (person_pos_y),
		.person_valid         (person_valid),
		.last_person          (last_person),
		.speed_limit          (speed_limit),
		.goal_weight_halves   (goal_weight_halves),
		.social_weight_halves (social_weight_halves),
		.nearest_dist_sq      (nearest_dist_sq),
		.someone_ahead        (someone_ahead),
		.ahead_count          (ahead_count)
	);

	// an accepted item keeps the block busy in the following cycle
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle right after accept")
	// a result never loads while the block is idle for input
	`ASSERT_IMPL(a_load_when_busy, cmd.load_out, in_stall, "result loaded while idle")
	// ahead flag agrees with the count
	`ASSERT_IMPL(a_ahead_count, out_valid, someone_ahead == (ahead_count != '0),
		"ahead flag and count disagree")
	// goal code stays within its ladder
	`ASSERT_IMPL(a_goal_range, out_valid,
		goal_weight_halves == GOAL_CLOSE || goal_weight_halves == GOAL_MID ||
		goal_weight_halves == GOAL_FAR || goal_weight_halves == GOAL_OPEN,
		"goal code out of range")

endmodule
`default_nettype wire
